FILE: hdl/cgs_pkg.sv
// ----------------------------------------------------------------------------
// cgs_pkg
// Shared types, widths and codes for the congruence sieve solver.
// ----------------------------------------------------------------------------
package cgs_pkg;

    // Bits of a modulus or offset that take part in the arithmetic
    localparam int MODULUS_BITS = 10;
    // Width of the modulus and offset fields on the input channel
    localparam int FIELD_W      = 10;
    localparam int MOD_W        = (MODULUS_BITS < FIELD_W) ? MODULUS_BITS : FIELD_W;

    // Running multiplier, step and timestamp width
    localparam int WORD_W = 64;
    localparam int HALF_W = WORD_W / 2;
    localparam int IDX_W  = $clog2(WORD_W);
    localparam int PROD_W = HALF_W + MOD_W;
    // step * m with room to see an overflow past WORD_W
    localparam int FULL_W = WORD_W + MOD_W + 1;

    // Result status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NO_SOLUTION = 2'd1;
    localparam logic [1:0] ST_OVERFLOW    = 2'd2;

    // One congruence
    typedef struct packed {
        logic [FIELD_W-1:0] modulus;
        logic [FIELD_W-1:0] slot_offset;
        logic               last_item;
    } cgs_in_t;

    // One result
    typedef struct packed {
        logic [WORD_W-1:0] timestamp;
        logic [1:0]        status;
    } cgs_out_t;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_REDUCE,
        OP_MODMUL,
        OP_COMBINE,
        OP_SIEVE,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_STEP_UPD,
        OP_TS_LO,
        OP_TS_HI,
        OP_TS_SUM,
        OP_TS_SUB
    } cgs_op_t;

    // Source of the emitted timestamp
    typedef enum logic [1:0] {
        TS_CALC,
        TS_ONE,
        TS_ZERO
    } cgs_ts_sel_t;

    typedef struct packed {
        logic             capture;
        logic             load_ref;
        cgs_op_t          op;
        logic [IDX_W-1:0] idx;
        logic             load_out;
        cgs_ts_sel_t      ts_sel;
        logic [1:0]       out_status;
    } cgs_cmd_t;

    typedef struct packed {
        logic in_last;
        logic in_m_zero;
        logic r_zero;
        logic t_eq_m;
        logic ovf;
    } cgs_sts_t;

endpackage

FILE: hdl/cgs_datapath.sv
// ----------------------------------------------------------------------------
// cgs_datapath
// Residue reduction, modular multiply, sieve loop, step update and
// final timestamp arithmetic, all driven by the controller.
// ----------------------------------------------------------------------------
module cgs_datapath
    import cgs_pkg::*;
(
    input  logic     clk,
    input  cgs_in_t  item,
    input  cgs_cmd_t cmd,
    output cgs_sts_t sts,
    output cgs_out_t result
);

    // v < 2m -> v mod m
    function automatic logic [MOD_W-1:0] red_once(input logic [MOD_W:0] v,
                                                  input logic [MOD_W-1:0] m);
        logic [MOD_W:0] mx;
        logic [MOD_W:0] diff;
        mx   = {1'b0, m};
        diff = v - mx;
        return (v >= mx) ? diff[MOD_W-1:0] : v[MOD_W-1:0];
    endfunction

    // v < 3m -> v mod m
    function automatic logic [MOD_W-1:0] red_twice(input logic [MOD_W+1:0] v,
                                                   input logic [MOD_W-1:0] m);
        logic [MOD_W+1:0] m1;
        logic [MOD_W+1:0] m2;
        logic [MOD_W+1:0] d1;
        logic [MOD_W+1:0] d2;
        m1 = {2'b00, m};
        m2 = {1'b0, m, 1'b0};
        d1 = v - m1;
        d2 = v - m2;
        if (v >= m2)
            return d2[MOD_W-1:0];
        else if (v >= m1)
            return d1[MOD_W-1:0];
        else
            return v[MOD_W-1:0];
    endfunction

    logic [MOD_W-1:0]  m_reg, o_reg, ref_m_reg, ref_o_reg;
    logic [WORD_W-1:0] mult_reg, step_reg, ts_reg;
    logic [MOD_W-1:0]  acc_mult_reg, acc_step_reg, acc_rm_reg, acc_o_reg, acc_ro_reg;
    logic [MOD_W-1:0]  p1_reg, p2_reg, r_reg, delta_reg, t_reg;
    logic [PROD_W-1:0] prod_lo_reg, prod_hi_reg;
    cgs_out_t          result_reg;

    logic [MOD_W-1:0]  in_m, in_o;
    logic [WORD_W-1:0] rm_ext, o_ext, ro_ext, rm_acc_ext;
    logic [HALF_W-1:0] mul_a;
    logic [MOD_W-1:0]  mul_b;
    logic [PROD_W-1:0] mul_p;
    logic [FULL_W-1:0] step_full;
    logic [MOD_W-1:0]  comb_s1, comb_s2;
    logic              mm_bit;

    assign in_m = item.modulus[MOD_W-1:0];
    assign in_o = item.slot_offset[MOD_W-1:0];

    assign rm_ext     = WORD_W'(ref_m_reg);
    assign o_ext      = WORD_W'(o_reg);
    assign ro_ext     = WORD_W'(ref_o_reg);
    assign rm_acc_ext = WORD_W'(acc_rm_reg);
    assign mm_bit     = rm_acc_ext[cmd.idx];

    // Shared 32 x MOD_W multiplier
    always_comb
    begin
        case (cmd.op)
            OP_MUL_LO: begin mul_a = step_reg[HALF_W-1:0];      mul_b = m_reg;     end
            OP_MUL_HI: begin mul_a = step_reg[WORD_W-1:HALF_W]; mul_b = m_reg;     end
            OP_TS_LO:  begin mul_a = mult_reg[HALF_W-1:0];      mul_b = ref_m_reg; end
            OP_TS_HI:  begin mul_a = mult_reg[WORD_W-1:HALF_W]; mul_b = ref_m_reg; end
            default:   begin mul_a = '0;                        mul_b = '0;        end
        endcase
    end
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // step * m assembled from the two partial products
    assign step_full = {1'b0, prod_hi_reg, {HALF_W{1'b0}}} + FULL_W'(prod_lo_reg);

    // Initial residue of the sieve
    assign comb_s1 = red_once({1'b0, p1_reg} + {1'b0, acc_o_reg}, m_reg);
    assign comb_s2 = red_once({1'b0, comb_s1} + {1'b0, m_reg} - {1'b0, acc_ro_reg}, m_reg);

    // Status to the controller
    assign sts.in_last   = item.last_item;
    assign sts.in_m_zero = (in_m == '0);
    assign sts.r_zero    = (r_reg == '0);
    assign sts.t_eq_m    = (t_reg == m_reg);
    assign sts.ovf       = |step_full[FULL_W-1:WORD_W];

    always_ff @(posedge clk)
    begin
        // Latch the transaction and clear the reduction accumulators
        if (cmd.capture)
        begin
            m_reg        <= in_m;
            o_reg        <= in_o;
            acc_mult_reg <= '0;
            acc_step_reg <= '0;
            acc_rm_reg   <= '0;
            acc_o_reg    <= '0;
            acc_ro_reg   <= '0;
            p1_reg       <= '0;
            p2_reg       <= '0;
        end
        if (cmd.load_ref)
        begin
            ref_m_reg <= in_m;
            ref_o_reg <= in_o;
            mult_reg  <= '0;
            step_reg  <= WORD_W'(1);
        end

        case (cmd.op)
            // One bit per cycle, MSB first
            OP_REDUCE:
            begin
                acc_mult_reg <= red_once({acc_mult_reg, mult_reg[cmd.idx]}, m_reg);
                acc_step_reg <= red_once({acc_step_reg, step_reg[cmd.idx]}, m_reg);
                acc_rm_reg   <= red_once({acc_rm_reg, rm_ext[cmd.idx]}, m_reg);
                acc_o_reg    <= red_once({acc_o_reg, o_ext[cmd.idx]}, m_reg);
                acc_ro_reg   <= red_once({acc_ro_reg, ro_ext[cmd.idx]}, m_reg);
            end
            // Shift-add modular multiply by the reduced reference modulus
            OP_MODMUL:
            begin
                p1_reg <= red_twice({1'b0, p1_reg, 1'b0}
                                    + {2'b00, (mm_bit ? acc_mult_reg : '0)}, m_reg);
                p2_reg <= red_twice({1'b0, p2_reg, 1'b0}
                                    + {2'b00, (mm_bit ? acc_step_reg : '0)}, m_reg);
            end
            OP_COMBINE:
            begin
                r_reg     <= comb_s2;
                delta_reg <= p2_reg;
                t_reg     <= '0;
            end
            // One trial per cycle
            OP_SIEVE:
            begin
                if (!sts.t_eq_m && !sts.r_zero)
                begin
                    mult_reg <= mult_reg + step_reg;
                    r_reg    <= red_once({1'b0, r_reg} + {1'b0, delta_reg}, m_reg);
                    t_reg    <= t_reg + MOD_W'(1);
                end
            end
            OP_MUL_LO, OP_TS_LO: prod_lo_reg <= mul_p;
            OP_MUL_HI, OP_TS_HI: prod_hi_reg <= mul_p;
            OP_STEP_UPD:
            begin
                if (!sts.ovf)
                    step_reg <= step_full[WORD_W-1:0];
            end
            OP_TS_SUM: ts_reg <= WORD_W'(prod_lo_reg) + {prod_hi_reg[HALF_W-1:0], {HALF_W{1'b0}}};
            OP_TS_SUB: ts_reg <= ts_reg - WORD_W'(ref_o_reg);
            default: ;
        endcase

        // Output register
        if (cmd.load_out)
        begin
            case (cmd.ts_sel)
                TS_ONE:  result_reg.timestamp <= WORD_W'(1);
                TS_ZERO: result_reg.timestamp <= '0;
                default: result_reg.timestamp <= ts_reg;
            endcase
            result_reg.status <= cmd.out_status;
        end
    end

    assign result = result_reg;

endmodule

FILE: hdl/cgs_ctrl.sv
// ----------------------------------------------------------------------------
// cgs_ctrl
// Sequencer for the sieve: set bookkeeping, phase counters, error
// tracking and the result valid flag.
// ----------------------------------------------------------------------------
module cgs_ctrl
    import cgs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    output logic     result_valid,
    input  logic     result_ready,
    input  cgs_sts_t sts,
    output cgs_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_REDUCE,
        S_MODMUL,
        S_COMBINE,
        S_SIEVE,
        S_MUL_LO,
        S_MUL_HI,
        S_STEP_UPD,
        S_TS_LO,
        S_TS_HI,
        S_TS_SUM,
        S_TS_SUB,
        S_EMIT
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             have_ref_reg, have_ref_next;
    logic             gt1_reg, gt1_next;
    logic             last_reg, last_next;
    logic [1:0]       err_reg, err_next;
    logic             out_valid_reg, out_valid_next;

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;

    // Next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        have_ref_next  = have_ref_reg;
        gt1_next       = gt1_reg;
        last_next      = last_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !result_ready;

        cmd.capture    = 1'b0;
        cmd.load_ref   = 1'b0;
        cmd.op         = OP_NONE;
        cmd.idx        = idx_reg;
        cmd.load_out   = 1'b0;
        cmd.ts_sel     = TS_CALC;
        cmd.out_status = err_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    last_next   = sts.in_last;
                    if (!have_ref_reg)
                    begin
                        // First congruence of a set becomes the reference
                        cmd.load_ref  = 1'b1;
                        have_ref_next = 1'b1;
                        gt1_next      = 1'b0;
                        err_next      = ST_OK;
                        state_next    = sts.in_last ? S_EMIT : S_IDLE;
                    end
                    else
                    begin
                        gt1_next = 1'b1;
                        if (err_reg != ST_OK)
                            state_next = sts.in_last ? S_EMIT : S_IDLE;
                        else if (sts.in_m_zero)
                        begin
                            err_next   = ST_NO_SOLUTION;
                            state_next = sts.in_last ? S_EMIT : S_IDLE;
                        end
                        else
                        begin
                            state_next = S_REDUCE;
                            idx_next   = IDX_W'(WORD_W - 1);
                        end
                    end
                end
            end
            S_REDUCE:
            begin
                cmd.op = OP_REDUCE;
                if (idx_reg == '0)
                begin
                    state_next = S_MODMUL;
                    idx_next   = IDX_W'(MOD_W - 1);
                end
                else
                    idx_next = idx_reg - IDX_W'(1);
            end
            S_MODMUL:
            begin
                cmd.op = OP_MODMUL;
                if (idx_reg == '0)
                    state_next = S_COMBINE;
                else
                    idx_next = idx_reg - IDX_W'(1);
            end
            S_COMBINE:
            begin
                cmd.op     = OP_COMBINE;
                state_next = S_SIEVE;
            end
            S_SIEVE:
            begin
                cmd.op = OP_SIEVE;
                if (sts.t_eq_m)
                begin
                    // Trials used up: moduli share a factor
                    err_next   = ST_NO_SOLUTION;
                    state_next = last_reg ? S_EMIT : S_IDLE;
                end
                else if (sts.r_zero)
                    state_next = S_MUL_LO;
            end
            S_MUL_LO:
            begin
                cmd.op     = OP_MUL_LO;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd.op     = OP_MUL_HI;
                state_next = S_STEP_UPD;
            end
            S_STEP_UPD:
            begin
                cmd.op = OP_STEP_UPD;
                if (sts.ovf)
                begin
                    err_next   = ST_OVERFLOW;
                    state_next = last_reg ? S_EMIT : S_IDLE;
                end
                else
                    state_next = last_reg ? S_TS_LO : S_IDLE;
            end
            S_TS_LO:
            begin
                cmd.op     = OP_TS_LO;
                state_next = S_TS_HI;
            end
            S_TS_HI:
            begin
                cmd.op     = OP_TS_HI;
                state_next = S_TS_SUM;
            end
            S_TS_SUM:
            begin
                cmd.op     = OP_TS_SUM;
                state_next = S_TS_SUB;
            end
            S_TS_SUB:
            begin
                cmd.op     = OP_TS_SUB;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!gt1_reg)
                    cmd.ts_sel = TS_ONE;
                else if (err_reg != ST_OK)
                    cmd.ts_sel = TS_ZERO;
                else
                    cmd.ts_sel = TS_CALC;
                // Wait for the output register to free up
                if (!out_valid_reg || result_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    have_ref_next  = 1'b0;
                    gt1_next       = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            have_ref_reg  <= 1'b0;
            gt1_reg       <= 1'b0;
            last_reg      <= 1'b0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            have_ref_reg  <= have_ref_next;
            gt1_reg       <= gt1_next;
            last_reg      <= last_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A last congruence closes the input until its result is handled
    a_last_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && sts.in_last) |=> !item_ready)
        else $error("input accepted right after a last congruence");

    // A result appears only out of the emit state
    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result valid raised outside emit");

    // The reduction sweep runs straight into the modular multiply
    a_reduce_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REDUCE) |=> (state_reg == S_REDUCE || state_reg == S_MODMUL))
        else $error("reduction sweep left early");

    // Running out of trials always records no solution
    a_sieve_giveup: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SIEVE && sts.t_eq_m) |=> (err_reg == ST_NO_SOLUTION))
        else $error("sieve gave up without flagging no solution");

endmodule

FILE: hdl/congruence_sieve_solver.sv
// ----------------------------------------------------------------------------
// congruence_sieve_solver
// Earliest time meeting a set of congruences, by the sieve method.
// ----------------------------------------------------------------------------
// Usage:
//   The item channel takes one congruence per transaction (modulus,
//   slot_offset, last_item). The first transaction of a set is the
//   reference; last_item closes the set and yields one transaction on the
//   result channel (timestamp, status). Non-last items give no result.
//   A reference item is only latched as the reference. A later item goes
//   through acceptance, a bit-serial residue reduction over all 64
//   bits, a shift-add modular multiply over the MOD_W bits, a combine
//   step, the sieve loop (one 64-bit add per cycle, at most m trials)
//   and the step update (low and high partial products, then the sum) on
//   the shared 32 x MOD_W multiplier. A last item then adds the timestamp
//   multiply and subtract before the result is registered. Items are
//   handled one at a time; item_ready is high only while idle. Reset
//   (rst_n low, asynchronous) empties the output register and ends any
//   open set. A stalled receiver holds the result in the output register;
//   further items are still taken until the next result is ready to be
//   registered, and input then waits.
// ----------------------------------------------------------------------------
module congruence_sieve_solver
    import cgs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  cgs_in_t  item,
    output logic     result_valid,
    input  logic     result_ready,
    output cgs_out_t result
);

    cgs_cmd_t cmd;
    cgs_sts_t sts;

    // Sequencer
    cgs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    // Arithmetic
    cgs_datapath u_datapath (
        .clk    (clk),
        .item   (item),
        .cmd    (cmd),
        .sts    (sts),
        .result (result)
    );

endmodule

FILE: sim/congruence_sieve_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// congruence_sieve_checker
// Watches both channels of the congruence sieve solver. Each accepted
// congruence updates a local copy of the sieve state; each closed set queues
// the solution it should produce, which is compared against the result
// channel in order.
// ----------------------------------------------------------------------------
module congruence_sieve_checker
    import cgs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    input  logic     item_ready,
    input  cgs_in_t  item,
    input  logic     result_valid,
    input  logic     result_ready,
    input  cgs_out_t result,
    output int       fail_count,
    output int       pending
);

    localparam longint unsigned FIELD_MASK = (64'd1 << MODULUS_BITS) - 64'd1;
    localparam longint unsigned WORD_MAX   = 64'hFFFF_FFFF_FFFF_FFFF;

    // Sieve state of the open set
    longint unsigned ref_period = 0;
    longint unsigned ref_shift  = 0;
    longint unsigned coeff      = 0;
    longint unsigned stride     = 1;
    logic            anchored   = 1'b0;
    logic            combined   = 1'b0;
    logic [1:0]      fault      = ST_OK;

    cgs_out_t solution_q[$];
    int       mismatches = 0;

    // Fold one congruence into the set; queue the solution on a last item
    task automatic absorb_congruence(input cgs_in_t c);
        longint unsigned m;
        longint unsigned o;
        longint unsigned r;
        longint unsigned delta;
        longint unsigned trials;
        cgs_out_t        sol;
        m = 64'(c.modulus) & FIELD_MASK;
        o = 64'(c.slot_offset) & FIELD_MASK;
        if (!anchored)
        begin
            ref_period = m;
            ref_shift  = o;
            coeff      = 0;
            stride     = 1;
            anchored   = 1'b1;
            combined   = 1'b0;
            fault      = ST_OK;
        end
        else
        begin
            combined = 1'b1;
            // errors are sticky until the set closes
            if (fault == ST_OK)
            begin
                if (m == 0)
                    fault = ST_NO_SOLUTION;
                else
                begin
                    // residue of t + o, tracked exactly so negative t is fine
                    r = ((ref_period % m) * (coeff % m)) % m;
                    r = (r + o % m) % m;
                    r = (r + m - ref_shift % m) % m;
                    delta = ((ref_period % m) * (stride % m)) % m;
                    trials = 0;
                    while (trials < m && r != 0)
                    begin
                        coeff  = coeff + stride;
                        r      = (r + delta) % m;
                        trials = trials + 1;
                    end
                    if (trials == m)
                        fault = ST_NO_SOLUTION;
                    else if (stride > WORD_MAX / m)
                        fault = ST_OVERFLOW;
                    else
                        stride = stride * m;
                end
            end
        end
        if (c.last_item)
        begin
            sol.status = fault;
            if (!combined)
                sol.timestamp = 64'd1;
            else if (fault != ST_OK)
                sol.timestamp = 64'd0;
            else
                sol.timestamp = ref_period * coeff - ref_shift;
            solution_q = {solution_q, sol};
            anchored = 1'b0;
            combined = 1'b0;
        end
    endtask

    // Compare results, then absorb the congruence taken at this edge
    always @(posedge clk or negedge rst_n)
    begin
        cgs_out_t want;
        if (!rst_n)
        begin
            ref_period = 0;
            ref_shift  = 0;
            coeff      = 0;
            stride     = 1;
            anchored   = 1'b0;
            combined   = 1'b0;
            fault      = ST_OK;
            solution_q.delete();
            mismatches = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (solution_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result, timestamp %h status %0d",
                                 $time, result.timestamp, result.status);
                    mismatches++;
                end
                else
                begin
                    want = solution_q.pop_front();
                    if (result.timestamp !== want.timestamp ||
                        result.status !== want.status)
                    begin
                        if (mismatches < 10)
                            $display({"%0t: result mismatch, expected timestamp %h ",
                                      "status %0d, got timestamp %h status %0d"},
                                     $time, want.timestamp, want.status,
                                     result.timestamp, result.status);
                        mismatches++;
                    end
                end
            end
            if (item_valid && item_ready)
                absorb_congruence(item);
            fail_count <= mismatches;
            pending    <= solution_q.size();
        end
    end

endmodule

FILE: sim/congruence_sieve_solver_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// congruence_sieve_solver_test
// Drives sets of congruences into the sieve solver: a directed group of
// corner cases, then random sets (mostly coprime moduli, some broken sets
// and stray items) under three idling mixes and one long result stall.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module congruence_sieve_solver_test;
    import cgs_pkg::*;

    localparam int ITEM_TARGET   = 540;
    localparam int HOLD_CYCLES   = 3000;
    localparam int SETTLE_CYCLES = 1200;
    localparam int CYCLE_LIMIT   = 3_000_000;

    logic     clk          = 1'b0;
    logic     rst_n        = 1'b0;
    logic     item_valid   = 1'b0;
    logic     item_ready;
    cgs_in_t  item         = '0;
    logic     result_valid;
    logic     result_ready = 1'b0;
    cgs_out_t result;

    int   fail_count;
    int   pending;
    int   send_idle_pct    = 20;
    int   recv_idle_pct    = 72;
    logic hold_tog         = 1'b0;
    logic hold_seen        = 1'b0;
    int   hold_left        = 0;
    int   cycle_count      = 0;
    int   congruences_sent = 0;

    always #10 clk = ~clk;

    congruence_sieve_solver dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    congruence_sieve_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // Result receiver: random stalls, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_tog != hold_seen)
        begin
            hold_seen = hold_tog;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic cgs_in_t congruence(int unsigned m, int unsigned o, bit last);
        cgs_in_t c;
        c.modulus     = FIELD_W'(m);
        c.slot_offset = FIELD_W'(o);
        c.last_item   = last;
        return c;
    endfunction

    // One transaction on the item channel, then maybe an idle gap
    task automatic offer(input cgs_in_t c);
        int gap;
        item       <= c;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        congruences_sent++;
        if ($urandom_range(99) < send_idle_pct)
        begin
            gap = ($urandom_range(7) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 6);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering until every queued solution has come out
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // A set of len congruences; later moduli coprime to all earlier ones if asked
    task automatic send_set(int len, int unsigned lo, int unsigned hi, bit coprime);
        int unsigned mods[16];
        int unsigned m;
        int unsigned a;
        int unsigned b;
        int unsigned t;
        bit          ok;
        for (int i = 0; i < len; i++)
        begin
            m = $urandom_range(lo, hi);
            if (i > 0 && coprime)
            begin
                ok = 1'b0;
                for (int k = 0; k < 16 && !ok; k++)
                begin
                    m  = $urandom_range(lo, hi);
                    ok = 1'b1;
                    for (int j = 0; j < i; j++)
                    begin
                        a = m;
                        b = mods[j];
                        while (b != 0)
                        begin
                            t = a % b;
                            a = b;
                            b = t;
                        end
                        if (a != 1)
                            ok = 1'b0;
                    end
                end
                if (!ok)
                    m = 1;
            end
            mods[i] = m;
            offer(congruence(m, $urandom_range(0, 1023), i == len - 1));
        end
    endtask

    initial
    begin
        int  pick;
        int  len;
        int  unsigned lo;
        int  unsigned hi;
        int  phase;
        int  cur_phase;
        bit  hold_done;
        hold_done = 1'b0;
        cur_phase = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-item set
        offer(congruence(1023, 1023, 1'b1));
        // negative time: multiplier stays 0 with a nonzero reference offset
        offer(congruence(7, 5, 1'b0));
        offer(congruence(1, 0, 1'b1));
        // shared factor, no solution within the trial limit
        offer(congruence(4, 0, 1'b0));
        offer(congruence(6, 1, 1'b1));
        // zero modulus on a later item
        offer(congruence(5, 0, 1'b0));
        offer(congruence(0, 0, 1'b1));
        // zero reference modulus
        offer(congruence(0, 3, 1'b0));
        offer(congruence(7, 3, 1'b1));
        // step overflow, then a later item ignored by the sticky error
        offer(congruence(1021, 17, 1'b0));
        offer(congruence(1019, 1, 1'b0));
        offer(congruence(1013, 2, 1'b0));
        offer(congruence(1009, 3, 1'b0));
        offer(congruence(997, 4, 1'b0));
        offer(congruence(991, 5, 1'b0));
        offer(congruence(983, 6, 1'b0));
        offer(congruence(977, 7, 1'b0));
        offer(congruence(13, 2, 1'b1));
        // classic bus schedule set
        offer(congruence(7, 0, 1'b0));
        offer(congruence(13, 1, 1'b0));
        offer(congruence(59, 4, 1'b0));
        offer(congruence(31, 6, 1'b0));
        offer(congruence(19, 7, 1'b1));
        // extreme modulus and offset against a unit reference
        offer(congruence(1, 0, 1'b0));
        offer(congruence(1023, 1023, 1'b1));

        // random sets
        while (congruences_sent < ITEM_TARGET)
        begin
            phase = (congruences_sent < 215) ? 0 : (congruences_sent < 390) ? 1 : 2;
            if (phase != cur_phase)
            begin
                cur_phase = phase;
                drain();
                send_idle_pct <= (phase == 1) ? 72 : 0;
                recv_idle_pct <= (phase == 1) ? 20 : 0;
            end

            // long receiver hold-off while sets keep coming
            if (!hold_done && congruences_sent >= 300)
            begin
                hold_done = 1'b1;
                hold_tog <= ~hold_tog;
                repeat (3) send_set(3, 2, 40, 1'b1);
                drain();
            end

            pick = $urandom_range(99);
            if (pick < 8)
            begin
                // stray items with arbitrary fields
                repeat ($urandom_range(1, 3))
                    offer(congruence($urandom_range(0, 1023), $urandom_range(0, 1023),
                                     $urandom_range(1)));
            end
            else
            begin
                pick = $urandom_range(99);
                lo   = 1;
                hi   = (pick < 65) ? 63 : 1023;
                if (pick >= 90)
                    lo = 512;
                pick = $urandom_range(99);
                len  = (pick < 10) ? 1 : (pick < 85) ? $urandom_range(2, 6) : $urandom_range(7, 10);
                send_set(len, lo, hi, $urandom_range(99) < 85);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
